### design/bsut_pkg.sv
package bsut_pkg;

  localparam int          PERIOD_W     = 16;
  localparam int          TIMER_W      = 17;
  localparam int          CNT_W        = 4;
  localparam int          BYTE_W       = 8;
  localparam int          DATA_BITS_DEF = 8;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 16'd4;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1664;

  typedef enum logic [3:0] {
    TX_IDLE  = 4'b0001,
    TX_START = 4'b0010,
    TX_DATA  = 4'b0100,
    TX_STOP  = 4'b1000
  } tx_state_t;

  typedef enum logic [3:0] {
    RX_IDLE     = 4'b0001,
    RX_START    = 4'b0010,
    RX_DATA     = 4'b0100,
    RX_STOPWAIT = 4'b1000
  } rx_state_t;

  typedef struct packed {
    logic              tx_line;
    logic              tx_busy;
    logic              rx_valid;
    logic [BYTE_W-1:0] rx_byte;
  } res_t;

endpackage

### design/bit_serial_uart_transceiver.sv
// A tick request's result is registered in the output register, or in the skid stage
// if that is held. Throughput: one tick request per cycle unless stalled; each request
// advances transmitter and receiver by exactly one bit-clock tick, all in one pass of logic.
// Reset (rst_n, synchronous, active low): both state machines idle, timers and counts zero,
// bit period 1664, output register and skid stage empty.
module bit_serial_uart_transceiver
  import bsut_pkg::*;
#(
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [PERIOD_W-1:0] cfg_wr_data,
  // tick requests
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_rx_line,
  input  logic                in_tx_valid,
  input  logic [BYTE_W-1:0]   in_tx_byte,
  // results
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_tx_line,
  output logic                out_tx_busy,
  output logic                out_rx_valid,
  output logic [BYTE_W-1:0]   out_rx_byte
);

  localparam logic [CNT_W-1:0] NBITS = CNT_W'(DATA_BITS);

  // Bit period register
  logic [PERIOD_W-1:0] bit_period_r;
  logic [PERIOD_W-1:0] period;
  logic [TIMER_W-1:0]  period_x;
  logic [TIMER_W-1:0]  start_thr;

  // Transmitter state
  tx_state_t           tx_phase_r, tx_phase_nxt;
  logic [BYTE_W-1:0]   tx_shift_r, tx_shift_nxt;
  logic [CNT_W-1:0]    tx_cnt_r, tx_cnt_nxt;
  logic [TIMER_W-1:0]  tx_timer_r, tx_timer_nxt;

  // Receiver state
  rx_state_t           rx_phase_r, rx_phase_nxt;
  logic [BYTE_W-1:0]   rx_shift_r, rx_shift_nxt;
  logic [CNT_W-1:0]    rx_cnt_r, rx_cnt_nxt;
  logic [TIMER_W-1:0]  rx_timer_r, rx_timer_nxt;
  logic [TIMER_W-1:0]  rx_timer_inc;
  logic                rx_do_sample;
  logic                rx_got;

  // Output register and skid stage
  res_t                res_nxt;
  res_t                out_r, skid_r;
  logic                out_valid_r, skid_valid_r;
  logic                in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  // Stall only once the skid stage is occupied, so requests keep flowing while
  // a single result waits downstream.
  assign in_stall = skid_valid_r;

  // Periods below the minimum act as the minimum.
  assign period    = (bit_period_r < PERIOD_MIN) ? PERIOD_MIN : bit_period_r;
  assign period_x  = TIMER_W'(period);
  // First data sample lands mid-bit: one and a half periods after the start edge.
  assign start_thr = period_x + (period_x >> 1);

  // Transmitter: advance bit timing first, then take a new byte if now idle.
  always_comb begin
    tx_phase_nxt = tx_phase_r;
    tx_shift_nxt = tx_shift_r;
    tx_cnt_nxt   = tx_cnt_r;
    tx_timer_nxt = tx_timer_r;
    if (tx_phase_r != TX_IDLE) begin
      tx_timer_nxt = tx_timer_r + TIMER_W'(1);
      if (tx_timer_nxt >= period_x) begin
        tx_timer_nxt = '0;
        case (tx_phase_r)
          TX_START: begin
            tx_phase_nxt = TX_DATA;
            tx_cnt_nxt   = '0;
          end
          TX_DATA: begin
            tx_cnt_nxt = tx_cnt_r + CNT_W'(1);
            if (tx_cnt_nxt >= NBITS) tx_phase_nxt = TX_STOP;
          end
          default: begin
            tx_phase_nxt = TX_IDLE;
          end
        endcase
      end
    end
    // A request that finds the transmitter busy is dropped.
    if (tx_phase_nxt == TX_IDLE && in_tx_valid) begin
      tx_shift_nxt = in_tx_byte;
      tx_phase_nxt = TX_START;
      tx_cnt_nxt   = '0;
      tx_timer_nxt = '0;
    end
  end

  // Receiver: any low while idle starts a frame; sample at mid-bit; wait for high stop.
  always_comb begin
    rx_phase_nxt = rx_phase_r;
    rx_shift_nxt = rx_shift_r;
    rx_cnt_nxt   = rx_cnt_r;
    rx_timer_nxt = rx_timer_r;
    rx_got       = 1'b0;
    rx_timer_inc = rx_timer_r + TIMER_W'(1);
    rx_do_sample = 1'b0;
    case (rx_phase_r)
      RX_IDLE: begin
        if (!in_rx_line) begin
          rx_phase_nxt = RX_START;
          rx_shift_nxt = '0;
          rx_cnt_nxt   = '0;
          rx_timer_nxt = '0;
        end
      end
      RX_START: begin
        rx_timer_nxt = rx_timer_inc;
        rx_do_sample = (rx_timer_inc >= start_thr);
      end
      RX_DATA: begin
        rx_timer_nxt = rx_timer_inc;
        rx_do_sample = (rx_timer_inc >= period_x);
      end
      default: begin
        if (in_rx_line) begin
          rx_phase_nxt = RX_IDLE;
          rx_timer_nxt = '0;
          rx_got       = 1'b1;
        end
      end
    endcase
    if (rx_do_sample) begin
      // A ninth data bit is counted but not stored.
      if (!rx_cnt_r[CNT_W-1] && in_rx_line) rx_shift_nxt[rx_cnt_r[CNT_W-2:0]] = 1'b1;
      rx_cnt_nxt   = rx_cnt_r + CNT_W'(1);
      rx_timer_nxt = '0;
      rx_phase_nxt = (rx_cnt_nxt >= NBITS) ? RX_STOPWAIT : RX_DATA;
    end
  end

  // Result fields come from the state after this tick's update.
  always_comb begin
    case (tx_phase_nxt)
      TX_START: res_nxt.tx_line = 1'b0;
      TX_DATA:  res_nxt.tx_line = tx_cnt_nxt[CNT_W-1] ? 1'b0
                                  : tx_shift_nxt[tx_cnt_nxt[CNT_W-2:0]];
      default:  res_nxt.tx_line = 1'b1;
    endcase
    res_nxt.tx_busy  = (tx_phase_nxt != TX_IDLE);
    res_nxt.rx_valid = rx_got;
    res_nxt.rx_byte  = rx_got ? rx_shift_nxt : '0;
  end

  // Machine state advances only on an accepted tick request; cfg_wr_en loads the bit period.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= PERIOD_RESET;
      tx_phase_r   <= TX_IDLE;
      tx_shift_r   <= '0;
      tx_cnt_r     <= '0;
      tx_timer_r   <= '0;
      rx_phase_r   <= RX_IDLE;
      rx_shift_r   <= '0;
      rx_cnt_r     <= '0;
      rx_timer_r   <= '0;
    end else begin
      if (cfg_wr_en) bit_period_r <= cfg_wr_data;
      if (in_acc) begin
        tx_phase_r <= tx_phase_nxt;
        tx_shift_r <= tx_shift_nxt;
        tx_cnt_r   <= tx_cnt_nxt;
        tx_timer_r <= tx_timer_nxt;
        rx_phase_r <= rx_phase_nxt;
        rx_shift_r <= rx_shift_nxt;
        rx_cnt_r   <= rx_cnt_nxt;
        rx_timer_r <= rx_timer_nxt;
      end
    end
  end

  // Output register with a skid stage behind it; results leave in order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_acc) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_acc;
        end
      end else if (in_acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_acc) begin
      if (skid_valid_r) out_r <= skid_r;
      else if (in_acc)  out_r <= res_nxt;
    end else if (in_acc) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_tx_line  = out_r.tx_line;
  assign out_tx_busy  = out_r.tx_busy;
  assign out_rx_valid = out_r.rx_valid;
  assign out_rx_byte  = out_r.rx_byte;

  // A result in the skid stage always has an older one ahead of it.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a result while the output register is empty");

  // Transmit bit count never runs past the frame length.
  a_tx_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    tx_cnt_r <= NBITS)
    else $error("transmit bit count beyond frame length");

  // An idle transmitter has a cleared timer.
  a_tx_idle_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (tx_phase_r == TX_IDLE) |-> (tx_timer_r == '0))
    else $error("transmit timer not cleared while idle");

  // A reported byte returns the receiver to idle with a cleared timer.
  a_rx_report_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && rx_got) |=> (rx_phase_r == RX_IDLE && rx_timer_r == '0))
    else $error("receiver did not return to idle after reporting a byte");

endmodule
